>>> design/xdsl_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the xor distance shortlist insert unit
// no dependencies

package xdsl_pkg;

  localparam int IdWidth     = 256;
  localparam int WordWidth   = 64;
  localparam int PeerWidth   = 64;
  localparam int CfgIdxWidth = 2;

  typedef logic [2:0] status_t;

  localparam status_t StatusUnverified  = 3'd0;
  localparam status_t StatusAuth        = 3'd1;
  localparam status_t StatusInFlight    = 3'd3;
  localparam status_t StatusUnreachable = 3'd5;
  localparam status_t StatusFailed      = 3'd6;

  localparam logic [CfgIdxWidth-1:0] CfgTarget0 = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTarget1 = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgTarget2 = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgTarget3 = 2'd3;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_CMP,
    FSM_DEC,
    FSM_APPLY
  } fsm_t;

  typedef enum logic [2:0] {
    OC_INSERTED = 3'd0,
    OC_ZERO_ID  = 3'd1,
    OC_DUP      = 3'd2,
    OC_BEYOND   = 3'd3,
    OC_NO_EVICT = 3'd4,
    OC_CLEARED  = 3'd5
  } outcome_t;

  typedef enum logic [1:0] {
    OP_KEEP,
    OP_LOAD_CAND,
    OP_LOAD_PREV,
    OP_UPDATE
  } cell_op_t;

  typedef struct packed {
    logic     cmp_en;
    cell_op_t op;
  } cell_ctrl_t;

  typedef struct packed {
    logic [IdWidth-1:0]   id;
    status_t              status;
    logic [PeerWidth-1:0] peer;
  } entry_t;

  typedef struct packed {
    logic                 mode;
    logic [WordWidth-1:0] node_word0;
    logic [WordWidth-1:0] node_word1;
    logic [WordWidth-1:0] node_word2;
    logic [WordWidth-1:0] node_word3;
    logic [2:0]           candidate_status;
    logic [PeerWidth-1:0] peer_ref;
  } req_t;

  typedef struct packed {
    logic       placed;
    logic [2:0] outcome;
    logic [3:0] slot;
    logic [4:0] entry_count;
    logic [4:0] frontier_count;
  } rsp_t;

endpackage

>>> design/xdsl_chan_if.sv
`timescale 1ns / 1ps
// valid/ready channels for candidate items and result items
// depends on xdsl_pkg

interface xdsl_req_if import xdsl_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface xdsl_rsp_if import xdsl_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/xdsl_cell.sv
`timescale 1ns / 1ps
// one shortlist cell: holds an entry, compares it with the candidate, shifts from its neighbor
// depends on xdsl_pkg

module xdsl_cell import xdsl_pkg::*; (
  input  logic               clk,
  input  cell_ctrl_t         ctrl,
  input  entry_t             cand,
  input  logic [IdWidth-1:0] target,
  input  entry_t             prev,
  output entry_t             entry,
  output logic               eq,
  output logic               closer
);

  entry_t entry_next;
  logic   upgrade;

  always_comb begin
    upgrade = (cand.status == StatusAuth) &&
              (entry.status inside {StatusUnverified, StatusUnreachable, StatusFailed});
    entry_next = entry;
    case (ctrl.op)
      OP_LOAD_CAND: entry_next = cand;
      OP_LOAD_PREV: entry_next = prev;
      OP_UPDATE: begin
        if (upgrade) begin
          entry_next.status = StatusAuth;
        end
        if (cand.peer != '0) begin
          entry_next.peer = cand.peer;
        end
      end
      default: entry_next = entry;
    endcase
  end

  // equal distances imply equal ids, so the distance compare alone orders them
  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (ctrl.cmp_en) begin
      eq     <= (entry.id == cand.id);
      closer <= ((cand.id ^ target) < (entry.id ^ target));
    end
  end

endmodule

>>> design/xor_distance_shortlist_insert_unit.sv
`timescale 1ns / 1ps
// top level of the xor distance shortlist insert unit
// depends on xdsl_pkg, xdsl_chan_if, xdsl_cell

// Keeps up to CAPACITY 256-bit node ids sorted by xor distance to the target held in
// four 64-bit registers. Each item passes these steps: one to accept, one in which all
// cells compare their entry with the candidate in parallel, one to pick the duplicate,
// the insert place and the eviction victim from the cell flags, and one in which the row
// of cells shifts in a single step and the result is loaded into the output register.
// The next item can be accepted only once the previous one leaves the last step,
// in the same cycle as its result is presented. That step waits while the previous
// result is still held. Write the target registers only while no item is in progress.

module xor_distance_shortlist_insert_unit import xdsl_pkg::*; #(
  parameter int CAPACITY      = 16,
  parameter int FRONTIER_SIZE = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CfgIdxWidth-1:0] wr_index,
  input  logic [WordWidth-1:0]   wr_data,
  xdsl_req_if.sink               req,
  xdsl_rsp_if.source             rsp
);

  localparam int IdxW = $clog2(CAPACITY);
  localparam int CntW = $clog2(CAPACITY + 1);

  logic [IdWidth-1:0] target;
  fsm_t               state;
  fsm_t               state_next;
  entry_t             cand;
  logic               cand_mode;
  logic [CntW-1:0]    fill;
  logic [CntW-1:0]    fill_next;
  outcome_t           dec_outcome;
  logic [IdxW-1:0]    dec_slot;
  logic [IdxW-1:0]    dec_end;
  logic               rsp_valid;
  rsp_t               rsp_data;

  entry_t             cell_entry [CAPACITY];
  logic               cell_eq    [CAPACITY];
  logic               cell_closer[CAPACITY];
  cell_ctrl_t         cell_ctrl  [CAPACITY];

  logic               accept;
  logic               cmp_en;
  logic               apply_fire;

  outcome_t           pick_outcome;
  logic [IdxW-1:0]    pick_slot;
  logic [IdxW-1:0]    pick_end;
  logic               dup_hit;
  logic [IdxW-1:0]    dup_idx;
  logic               at_found;
  logic [CntW-1:0]    at_c;
  logic               ev_found;
  logic [IdxW-1:0]    ev_idx;
  logic               full;

  logic [31:0]        cnt32;
  logic [31:0]        front32;
  logic [31:0]        slot32;

  // target registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (wr_en) begin
      case (wr_index)
        CfgTarget0: target[255:192] <= wr_data;
        CfgTarget1: target[191:128] <= wr_data;
        CfgTarget2: target[127:64]  <= wr_data;
        CfgTarget3: target[63:0]    <= wr_data;
        default:    target          <= target;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      FSM_IDLE:  if (req.valid) state_next = FSM_CMP;
      FSM_CMP:   state_next = FSM_DEC;
      FSM_DEC:   state_next = FSM_APPLY;
      FSM_APPLY: if (!rsp_valid || rsp.ready) state_next = FSM_IDLE;
      default:   state_next = FSM_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state == FSM_IDLE);
    cmp_en     = (state == FSM_CMP);
    apply_fire = (state == FSM_APPLY) && (!rsp_valid || rsp.ready);
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // candidate latch
  always_ff @(posedge clk) begin
    if (accept) begin
      cand.id     <= {req.data.node_word0, req.data.node_word1,
                      req.data.node_word2, req.data.node_word3};
      cand.status <= req.data.candidate_status;
      cand.peer   <= req.data.peer_ref;
      cand_mode   <= req.data.mode;
    end
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t prev_entry;
    if (g == 0) begin : g_head
      assign prev_entry = cand;
    end else begin : g_body
      assign prev_entry = cell_entry[g-1];
    end
    xdsl_cell u_cell (
      .clk    (clk),
      .ctrl   (cell_ctrl[g]),
      .cand   (cand),
      .target (target),
      .prev   (prev_entry),
      .entry  (cell_entry[g]),
      .eq     (cell_eq[g]),
      .closer (cell_closer[g])
    );
  end

  // decision from the cell flags
  always_comb begin
    dup_hit  = 1'b0;
    dup_idx  = '0;
    at_found = 1'b0;
    at_c     = fill;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CntW'(i) < fill) begin
        if (cell_eq[i] && !dup_hit) begin
          dup_hit = 1'b1;
          dup_idx = IdxW'(i);
        end
        if (cell_closer[i] && !at_found) begin
          at_found = 1'b1;
          at_c     = CntW'(i);
        end
      end
    end
    ev_found = 1'b0;
    ev_idx   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((CntW'(i) >= at_c) && (cell_entry[i].status != StatusInFlight)) begin
        ev_found = 1'b1;
        ev_idx   = IdxW'(i);
      end
    end
    full         = (fill == CntW'(CAPACITY));
    pick_outcome = OC_INSERTED;
    pick_slot    = '0;
    pick_end     = '0;
    if (cand_mode) begin
      pick_outcome = OC_CLEARED;
    end else if (cand.id == '0) begin
      pick_outcome = OC_ZERO_ID;
    end else if (dup_hit) begin
      pick_outcome = OC_DUP;
      pick_slot    = dup_idx;
    end else if (full && (at_c == CntW'(CAPACITY))) begin
      pick_outcome = OC_BEYOND;
    end else if (full && !ev_found) begin
      pick_outcome = OC_NO_EVICT;
    end else begin
      pick_outcome = OC_INSERTED;
      pick_slot    = at_c[IdxW-1:0];
      pick_end     = full ? ev_idx : fill[IdxW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == FSM_DEC) begin
      dec_outcome <= pick_outcome;
      dec_slot    <= pick_slot;
      dec_end     <= pick_end;
    end
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].cmp_en = cmp_en;
      cell_ctrl[i].op     = OP_KEEP;
      if (apply_fire) begin
        if (dec_outcome == OC_INSERTED) begin
          if (IdxW'(i) == dec_slot) begin
            cell_ctrl[i].op = OP_LOAD_CAND;
          end else if ((IdxW'(i) > dec_slot) && (IdxW'(i) <= dec_end)) begin
            cell_ctrl[i].op = OP_LOAD_PREV;
          end
        end else if ((dec_outcome == OC_DUP) && (IdxW'(i) == dec_slot)) begin
          cell_ctrl[i].op = OP_UPDATE;
        end
      end
    end
  end

  // fill count and result
  always_comb begin
    fill_next = fill;
    if (dec_outcome == OC_CLEARED) begin
      fill_next = '0;
    end else if ((dec_outcome == OC_INSERTED) && (fill != CntW'(CAPACITY))) begin
      fill_next = fill + CntW'(1);
    end
    cnt32   = 32'(fill_next);
    front32 = (cnt32 < 32'(FRONTIER_SIZE)) ? cnt32 : 32'(FRONTIER_SIZE);
    slot32  = 32'(dec_slot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (apply_fire) begin
        fill      <= fill_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      rsp_data.placed         <= (dec_outcome == OC_INSERTED);
      rsp_data.outcome        <= dec_outcome;
      rsp_data.slot           <= slot32[3:0];
      rsp_data.entry_count    <= cnt32[4:0];
      rsp_data.frontier_count <= front32[4:0];
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_item_seq: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 (state == FSM_APPLY))
    else $error("item did not reach the apply step in time");

  a_rsp_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == FSM_APPLY))
    else $error("result raised outside the apply step");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for xor_distance_shortlist_insert_unit: directed table, then random phases
// depends on xdsl_pkg, xdsl_chan_if and the unit itself

module tb;
  import xdsl_pkg::*;

  localparam int Capacity   = 16;
  localparam int Frontier   = 8;
  localparam int PhaseItems = 120;
  localparam int StallLimit = 1000;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeClear  = 1'b1;

  localparam status_t StatusQueried   = 3'd2;
  localparam status_t StatusResponded = 3'd4;
  localparam status_t StatusReserved  = 3'd7;

  typedef struct {
    logic         mode;
    logic [255:0] id;
    status_t      status;
    logic [63:0]  peer;
    bit           typed;
    rsp_t         want;
  } stim_row_t;

  typedef struct {
    bit   typed;
    rsp_t want;
  } typed_note_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   wr_en;
  logic [CfgIdxWidth-1:0] wr_index;
  logic [WordWidth-1:0]   wr_data;

  xdsl_req_if req_ch ();
  xdsl_rsp_if rsp_ch ();

  xor_distance_shortlist_insert_unit #(
    .CAPACITY     (Capacity),
    .FRONTIER_SIZE(Frontier)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_index(wr_index),
    .wr_data (wr_data),
    .req     (req_ch),
    .rsp     (rsp_ch)
  );

  always #5 clk = ~clk;

  // shadow copy of the shortlist and target
  entry_t       shortlist [Capacity];
  int           shortlist_fill;
  logic [255:0] target_id;

  rsp_t        expected_outcomes [$];
  typed_note_t typed_checks [$];

  int mismatches   = 0;
  int items_taken  = 0;
  int quiet_cycles = 0;
  int idle_odds    = 8;
  int inflight_pct = 15;
  int settings     = 1;
  int outcome_hits [6];

  function automatic bit sorts_closer(logic [255:0] cand, logic [255:0] held);
    logic [255:0] dc;
    logic [255:0] dh;
    dc = cand ^ target_id;
    dh = held ^ target_id;
    return (dc < dh) || (dc == dh && cand < held);
  endfunction

  function automatic rsp_t apply_candidate(req_t r);
    rsp_t         o;
    logic [255:0] cid;
    int           hit;
    int           place;
    int           victim;
    bit           ok;
    o = '0;
    cid = {r.node_word0, r.node_word1, r.node_word2, r.node_word3};
    if (r.mode == ModeClear) begin
      shortlist_fill = 0;
      o.outcome = OC_CLEARED;
    end else if (cid == '0) begin
      o.outcome = OC_ZERO_ID;
    end else begin
      hit = -1;
      for (int i = 0; i < shortlist_fill; i++)
        if (hit < 0 && shortlist[i].id == cid) hit = i;
      if (hit >= 0) begin
        if (r.candidate_status == StatusAuth &&
            (shortlist[hit].status == StatusUnverified ||
             shortlist[hit].status == StatusUnreachable ||
             shortlist[hit].status == StatusFailed))
          shortlist[hit].status = StatusAuth;
        if (r.peer_ref != '0) shortlist[hit].peer = r.peer_ref;
        o.outcome = OC_DUP;
        o.slot = hit[3:0];
      end else begin
        place = 0;
        while (place < shortlist_fill && !sorts_closer(cid, shortlist[place].id)) place++;
        victim = shortlist_fill;
        ok = 1'b1;
        if (shortlist_fill >= Capacity) begin
          if (place >= Capacity) begin
            ok = 1'b0;
            o.outcome = OC_BEYOND;
          end else begin
            victim = -1;
            for (int i = Capacity - 1; i >= place; i--)
              if (victim < 0 && shortlist[i].status != StatusInFlight) victim = i;
            if (victim < 0) begin
              ok = 1'b0;
              o.outcome = OC_NO_EVICT;
            end
          end
        end
        if (ok) begin
          for (int i = victim; i > place; i--) shortlist[i] = shortlist[i-1];
          shortlist[place].id = cid;
          shortlist[place].status = r.candidate_status;
          shortlist[place].peer = r.peer_ref;
          if (shortlist_fill < Capacity) shortlist_fill++;
          o.placed = 1'b1;
          o.outcome = OC_INSERTED;
          o.slot = place[3:0];
        end
      end
    end
    o.entry_count = 5'(shortlist_fill);
    o.frontier_count = 5'((shortlist_fill < Frontier) ? shortlist_fill : Frontier);
    return o;
  endfunction

  function automatic req_t to_req(logic mode, logic [255:0] id, status_t st, logic [63:0] peer);
    req_t r;
    r.mode = mode;
    {r.node_word0, r.node_word1, r.node_word2, r.node_word3} = id;
    r.candidate_status = st;
    r.peer_ref = peer;
    return r;
  endfunction

  function automatic logic [255:0] rand_id();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic req_t make_candidate();
    logic [255:0] spread;
    logic [255:0] id;
    logic [63:0]  peer;
    status_t      st;
    int           pick;
    pick = $urandom_range(0, 99);
    spread = rand_id();
    peer = ($urandom_range(0, 9) < 3) ? 64'd0 : {$urandom, $urandom};
    st = ($urandom_range(0, 99) < inflight_pct) ? StatusInFlight
                                                 : status_t'($urandom_range(0, 7));
    if (pick < 3) return to_req(ModeClear, spread, st, peer);
    if (pick < 5) begin
      id = '0;
    end else if (pick < 25 && shortlist_fill > 0) begin
      id = shortlist[$urandom_range(0, shortlist_fill - 1)].id;
      if ($urandom_range(0, 1) == 0) st = StatusAuth;
    end else if (pick < 40 && shortlist_fill > 0) begin
      // lands next to an entry already held
      id = shortlist[$urandom_range(0, shortlist_fill - 1)].id ^
           (spread >> $urandom_range(200, 255));
    end else if (pick < 75) begin
      id = target_id ^ (spread >> $urandom_range(0, 255));
    end else begin
      id = spread;
    end
    return to_req(ModeInsert, id, st, peer);
  endfunction

  // caller sits on a falling edge
  task automatic send_item(req_t r, bit typed, rsp_t want);
    int gap;
    gap = (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) ? $urandom_range(1, 13) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    typed_checks.push_back('{typed, want});
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [WordWidth-1:0] value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
  endtask

  task automatic write_target(logic [255:0] t);
    write_reg(CfgTarget0, t[255:192]);
    write_reg(CfgTarget1, t[191:128]);
    write_reg(CfgTarget2, t[127:64]);
    write_reg(CfgTarget3, t[63:0]);
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // result side stalls
  initial begin : rsp_pacer
    int hold;
    hold = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        rsp_ch.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(0, 99) < idle_odds) begin
        hold = $urandom_range(0, 12);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    rsp_t        got;
    rsp_t        want;
    typed_note_t note;
    if (rst) begin
      shortlist_fill = 0;
      target_id = '0;
      quiet_cycles = 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          CfgTarget0: target_id[255:192] = wr_data;
          CfgTarget1: target_id[191:128] = wr_data;
          CfgTarget2: target_id[127:64]  = wr_data;
          CfgTarget3: target_id[63:0]    = wr_data;
          default: ;
        endcase
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got = rsp_ch.data;
        if (got.outcome <= OC_CLEARED) outcome_hits[got.outcome]++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing pending: outcome %0d slot %0d count %0d",
                     got.outcome, got.slot, got.entry_count);
        end else begin
          want = expected_outcomes.pop_front();
          if (got.placed !== want.placed || got.outcome !== want.outcome ||
              got.slot !== want.slot || got.entry_count !== want.entry_count ||
              got.frontier_count !== want.frontier_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at %0t: want p%0d o%0d s%0d n%0d f%0d, got p%0d o%0d s%0d n%0d f%0d",
                       $realtime, want.placed, want.outcome, want.slot, want.entry_count,
                       want.frontier_count, got.placed, got.outcome, got.slot,
                       got.entry_count, got.frontier_count);
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        note = typed_checks.pop_front();
        want = apply_candidate(req_ch.data);
        expected_outcomes.push_back(note.typed ? note.want : want);
        items_taken++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("no handshake for %0d cycles", StallLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : driver
    stim_row_t    rows [$];
    logic [255:0] t;
    int           phase_idle [5];
    int           phase_inflight [5];
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = CfgTarget0;
    wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    phase_idle = '{6, 0, 12, 4, 0};
    phase_inflight = '{15, 10, 60, 25, 35};

    rows.push_back(stim_row_t'{ModeInsert, 256'd0, StatusUnverified, 64'd0, 1'b1,
                               rsp_t'{1'b0, OC_ZERO_ID, 4'd0, 5'd0, 5'd0}});
    rows.push_back(stim_row_t'{ModeClear, 256'd0, StatusUnverified, 64'd0, 1'b1,
                               rsp_t'{1'b0, OC_CLEARED, 4'd0, 5'd0, 5'd0}});
    rows.push_back(stim_row_t'{ModeInsert, 256'd1, StatusUnverified, 64'd0, 1'b0, '0});
    rows.push_back(stim_row_t'{ModeInsert, 256'd1, StatusAuth, '1, 1'b0, '0});
    for (int k = 1; k <= 14; k++)
      rows.push_back(stim_row_t'{ModeInsert, 256'(2 * k), StatusInFlight, 64'(k), 1'b0, '0});
    rows.push_back(stim_row_t'{ModeInsert, 256'd30, StatusReserved, 64'd0, 1'b0, '0});
    // full list: evicts the last entry that is not in flight
    rows.push_back(stim_row_t'{ModeInsert, 256'd3, StatusFailed, 64'd3, 1'b0, '0});
    rows.push_back(stim_row_t'{ModeInsert, 256'd5, StatusUnverified, 64'd5, 1'b1,
                               rsp_t'{1'b0, OC_NO_EVICT, 4'd0, 5'd16, 5'd8}});
    rows.push_back(stim_row_t'{ModeInsert, 256'd4, StatusAuth, 64'd0, 1'b0, '0});
    rows.push_back(stim_row_t'{ModeInsert, '1, StatusReserved, '1, 1'b1,
                               rsp_t'{1'b0, OC_BEYOND, 4'd0, 5'd16, 5'd8}});
    rows.push_back(stim_row_t'{ModeInsert, 256'd0, StatusQueried, 64'd9, 1'b1,
                               rsp_t'{1'b0, OC_ZERO_ID, 4'd0, 5'd16, 5'd8}});
    rows.push_back(stim_row_t'{ModeClear, '1, StatusResponded, '1, 1'b1,
                               rsp_t'{1'b0, OC_CLEARED, 4'd0, 5'd0, 5'd0}});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      @(negedge clk);
      send_item(to_req(rows[i].mode, rows[i].id, rows[i].status, rows[i].peer),
                rows[i].typed, rows[i].want);
    end

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      idle_odds = phase_idle[phase];
      inflight_pct = phase_inflight[phase];
      case (phase)
        0: t = '0;
        1: t = '1;
        default: t = rand_id();
      endcase
      write_target(t);
      settings++;
      repeat (PhaseItems) begin
        @(negedge clk);
        send_item(make_candidate(), 1'b0, '0);
      end
    end
    settle();
    mismatches += expected_outcomes.size();

    $display("%0d items over %0d target settings, %0d mismatches", items_taken, settings,
             mismatches);
    $display("inserted %0d, updated %0d, zero id %0d, beyond %0d, no slot %0d, cleared %0d",
             outcome_hits[OC_INSERTED], outcome_hits[OC_DUP], outcome_hits[OC_ZERO_ID],
             outcome_hits[OC_BEYOND], outcome_hits[OC_NO_EVICT], outcome_hits[OC_CLEARED]);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
